// ===== hdl/hsv_pkg.sv =====
package hsv_pkg;

  // Hue segment boundaries
  localparam logic [7:0] HUE_SEG1 = 8'd43;
  localparam logic [7:0] HUE_SEG2 = 8'd86;
  localparam logic [7:0] HUE_SEG3 = 8'd128;
  localparam logic [7:0] HUE_SEG4 = 8'd171;
  localparam logic [7:0] HUE_SEG5 = 8'd214;
  localparam logic [7:0] CHAN_MAX = 8'd255;
  localparam logic [7:0] CHAN_MIN = 8'd0;

  localparam int RAMP_IDX_W = 6;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // inverted full-saturation color plus the scale factors still to apply
  typedef struct packed {
    rgb_t       inv;
    logic [7:0] sat;
    logic [7:0] val;
  } sat_req_t;

  typedef struct packed {
    rgb_t       c;
    logic [7:0] val;
  } val_req_t;

  function automatic logic [7:0] ramp_lut(input logic [RAMP_IDX_W-1:0] idx);
    logic [7:0] v;
    unique case (idx)
      6'd0:  v = 8'd0;
      6'd1:  v = 8'd6;
      6'd2:  v = 8'd12;
      6'd3:  v = 8'd18;
      6'd4:  v = 8'd24;
      6'd5:  v = 8'd30;
      6'd6:  v = 8'd36;
      6'd7:  v = 8'd43;
      6'd8:  v = 8'd49;
      6'd9:  v = 8'd55;
      6'd10: v = 8'd61;
      6'd11: v = 8'd67;
      6'd12: v = 8'd73;
      6'd13: v = 8'd79;
      6'd14: v = 8'd85;
      6'd15: v = 8'd91;
      6'd16: v = 8'd97;
      6'd17: v = 8'd103;
      6'd18: v = 8'd109;
      6'd19: v = 8'd115;
      6'd20: v = 8'd121;
      6'd21: v = 8'd128;
      6'd22: v = 8'd134;
      6'd23: v = 8'd140;
      6'd24: v = 8'd146;
      6'd25: v = 8'd152;
      6'd26: v = 8'd158;
      6'd27: v = 8'd164;
      6'd28: v = 8'd170;
      6'd29: v = 8'd176;
      6'd30: v = 8'd182;
      6'd31: v = 8'd188;
      6'd32: v = 8'd194;
      6'd33: v = 8'd200;
      6'd34: v = 8'd206;
      6'd35: v = 8'd213;
      6'd36: v = 8'd219;
      6'd37: v = 8'd225;
      6'd38: v = 8'd231;
      6'd39: v = 8'd237;
      6'd40: v = 8'd243;
      6'd41: v = 8'd249;
      default: v = CHAN_MAX;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/hsv_if.sv =====
interface hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue_in;
  logic [7:0] saturation_in;
  logic [7:0] brightness_in;

  modport source (output valid, hue_in, saturation_in, brightness_in, input ready);
  modport sink   (input valid, hue_in, saturation_in, brightness_in, output ready);
endinterface

interface rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== hdl/hsv_to_rgb_pixel_converter.sv =====
// HSV to RGB pixel converter, 8 bits per channel. One pixel request is taken
// every clock cycle while the output is not stalled, and its RGB result is built
// in a three-stage pipeline: hue segment decode with ramp lookup, saturation
// multiply, then brightness multiply. Each stage holds its item while the
// output is stalled and fills any bubble ahead of it, so ready on the input
// follows ready on the output combinationally through the stage valid bits.
// No state is kept between pixels; reset only empties the pipeline.
module hsv_to_rgb_pixel_converter (
  input logic  clk,
  input logic  rst,
  hsv_if.sink  hsv,
  rgb_if.source rgb
);
  import hsv_pkg::*;

  logic     s1_valid, s1_ready;
  logic     s2_valid, s2_ready;
  sat_req_t s1_data;
  val_req_t s2_data;
  rgb_t     s3_data;

  hsv_hue_stage u_hue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsv.valid),
    .in_ready  (hsv.ready),
    .hue       (hsv.hue_in),
    .sat       (hsv.saturation_in),
    .val       (hsv.brightness_in),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  hsv_sat_stage u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  hsv_val_stage u_val (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .out_data  (s3_data)
  );

  assign rgb.red_out   = s3_data.r;
  assign rgb.green_out = s3_data.g;
  assign rgb.blue_out  = s3_data.b;

endmodule

// ===== hdl/hsv_hue_stage.sv =====
module hsv_hue_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       hue,
  input  logic [7:0]       sat,
  input  logic [7:0]       val,
  output logic             out_valid,
  input  logic             out_ready,
  output hsv_pkg::sat_req_t out_data
);
  import hsv_pkg::*;

  logic       valid;
  sat_req_t   data;
  sat_req_t   data_next;
  logic [7:0] off;
  logic [7:0] rv;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // every segment spans at most 43 hue steps, so the offset fits the ramp index
  assign rv = ramp_lut(off[RAMP_IDX_W-1:0]);

  always_comb begin
    priority if (hue < HUE_SEG1) begin
      off = hue;
    end else if (hue < HUE_SEG2) begin
      off = hue - HUE_SEG1;
    end else if (hue < HUE_SEG3) begin
      off = hue - HUE_SEG2;
    end else if (hue < HUE_SEG4) begin
      off = hue - HUE_SEG3;
    end else if (hue < HUE_SEG5) begin
      off = hue - HUE_SEG4;
    end else begin
      off = hue - HUE_SEG5;
    end
  end

  always_comb begin
    data_next.sat = sat;
    data_next.val = val;
    data_next.inv = '0;
    priority if (hue < HUE_SEG1) begin
      data_next.inv.r = CHAN_MIN;
      data_next.inv.g = CHAN_MAX - rv;
      data_next.inv.b = CHAN_MAX;
    end else if (hue < HUE_SEG2) begin
      data_next.inv.r = rv;
      data_next.inv.g = CHAN_MIN;
      data_next.inv.b = CHAN_MAX;
    end else if (hue < HUE_SEG3) begin
      data_next.inv.r = CHAN_MAX;
      data_next.inv.g = CHAN_MIN;
      data_next.inv.b = CHAN_MAX - rv;
    end else if (hue < HUE_SEG4) begin
      data_next.inv.r = CHAN_MAX;
      data_next.inv.g = rv;
      data_next.inv.b = CHAN_MIN;
    end else if (hue < HUE_SEG5) begin
      data_next.inv.r = CHAN_MAX - rv;
      data_next.inv.g = CHAN_MAX;
      data_next.inv.b = CHAN_MIN;
    end else begin
      data_next.inv.r = CHAN_MIN;
      data_next.inv.g = CHAN_MAX;
      data_next.inv.b = rv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== hdl/hsv_sat_stage.sv =====
module hsv_sat_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsv_pkg::sat_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsv_pkg::val_req_t out_data
);
  import hsv_pkg::*;

  logic       valid;
  val_req_t   data;
  val_req_t   data_next;
  logic [8:0] sat1;
  logic [16:0] pr, pg, pb;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  assign sat1 = {1'b0, in_data.sat} + 9'd1;
  assign pr   = {9'd0, in_data.inv.r} * {8'd0, sat1};
  assign pg   = {9'd0, in_data.inv.g} * {8'd0, sat1};
  assign pb   = {9'd0, in_data.inv.b} * {8'd0, sat1};

  // product >> 8 never exceeds 255, so bits [15:8] hold it
  always_comb begin
    data_next.c.r = CHAN_MAX - pr[15:8];
    data_next.c.g = CHAN_MAX - pg[15:8];
    data_next.c.b = CHAN_MAX - pb[15:8];
    data_next.val = in_data.val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== hdl/hsv_val_stage.sv =====
module hsv_val_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsv_pkg::val_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsv_pkg::rgb_t     out_data
);
  import hsv_pkg::*;

  logic        valid;
  rgb_t        data;
  rgb_t        data_next;
  logic [8:0]  val1;
  logic [16:0] pr, pg, pb;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  assign val1 = {1'b0, in_data.val} + 9'd1;
  assign pr   = {9'd0, in_data.c.r} * {8'd0, val1};
  assign pg   = {9'd0, in_data.c.g} * {8'd0, val1};
  assign pb   = {9'd0, in_data.c.b} * {8'd0, val1};

  always_comb begin
    data_next.r = pr[15:8];
    data_next.g = pg[15:8];
    data_next.b = pb[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== hdl/hsv_chk.sv =====
module hsv_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled result changed");

  // a waiting request is not withdrawn
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input request dropped");

  // a draining output means the pipeline can take a new request
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind hsv_to_rgb_pixel_converter hsv_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (hsv.valid),
  .in_ready  (hsv.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .red       (rgb.red_out),
  .green     (rgb.green_out),
  .blue      (rgb.blue_out)
);
